// ===== hw/rtl/mssd_pkg.sv =====
// ----------------------------------------------------------------------------
// mssd_pkg
// shared types and constants of the minimum subset-sum difference block
// ----------------------------------------------------------------------------
package mssd_pkg;

   localparam int VALUE_W = 10;
   localparam int DIFF_W  = 12;
   localparam int WORD_W  = 64;
   localparam int BIT_W   = 6;

   localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_data_type;

   typedef struct packed {
      logic [DIFF_W-1:0] min_difference;
      logic              overflow;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic sweep;
      logic search_init;
      logic search_rd;
      logic search_next;
      logic capture;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic k_zero;
      logic last;
      logic ovf;
      logic hit;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/mssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mssd_ctrl
// sequencer for the map sweep, the half-total search and the result hand-off
// ----------------------------------------------------------------------------
module mssd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mssd_pkg::status_type status,
   output mssd_pkg::cmd_type    cmd
);
   import mssd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_SEARCH,
      ST_TEST,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.k_zero) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            priority if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.ovf) begin
               cmd.capture = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_rd = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            if (status.hit) begin
               cmd.capture = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.search_next = 1'b1;
               state_in        = ST_SEARCH;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/mssd_datapath.sv =====
// ----------------------------------------------------------------------------
// mssd_datapath
// reachable-sum map memory, shift-or sweep pipe, running total, search and
// result register
// ----------------------------------------------------------------------------
module mssd_datapath #(
   parameter int MAX_SUM   = 4095,
   parameter int MAX_VALUE = 1023
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mssd_pkg::req_data_type req_data,
   input  mssd_pkg::cmd_type      cmd,
   output mssd_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mssd_pkg::rsp_data_type rsp_data
);
   import mssd_pkg::*;

   localparam int W        = MAX_SUM / WORD_W + 1;
   localparam int AW       = (W > 1) ? $clog2(W) : 1;
   localparam int KW       = $clog2(W + 1);
   localparam int TW       = $clog2(MAX_SUM + 1);
   localparam int SW       = ((TW > VALUE_W) ? TW : VALUE_W) + 1;
   localparam int CW       = ((KW > 4) ? KW : 4) + 1;
   localparam int DW       = ((TW > AW + BIT_W) ? TW : AW + BIT_W) + 2;
   localparam int TOP_BITS = MAX_SUM + 1 - WORD_W * (W - 1);
   localparam logic [WORD_W-1:0] TOP_MASK = {WORD_W{1'b1}} >> (WORD_W - TOP_BITS);

   // map storage and per-word valid bits
   logic [WORD_W-1:0] mem [W];
   logic [W-1:0]      vld_ff;

   // item registers
   logic [VALUE_W-1:0] v_ff;
   logic               last_ff;
   logic [TW-1:0]      total_ff;
   logic               ovf_ff;
   logic [KW-1:0]      k_ff;

   // sweep pipe
   logic              s1_valid_ff;
   logic [KW-1:0]     s1_k_ff;
   logic              a_ok_ff;
   logic              a0_ff;
   logic              b0_ff;
   logic              a_vld_ff;
   logic              b_vld_ff;
   logic [WORD_W-1:0] mem_a_ff;
   logic [WORD_W-1:0] mem_b_ff;
   logic [WORD_W-1:0] carry_ff;

   // search
   logic [AW-1:0] sk_ff;
   logic          sfirst_ff;

   // result
   rsp_data_type res_ff;
   rsp_data_type rsp_data_ff;
   logic         rsp_valid_ff;

   logic [VALUE_W-1:0]  v_sat;
   logic [SW-1:0]       sum_in;
   logic [3:0]          q;
   logic [BIT_W-1:0]    r;
   logic [CW-1:0]       src_diff;
   logic                a_ok;
   logic [AW-1:0]       a_addr;
   logic [AW-1:0]       b_addr;
   logic [WORD_W-1:0]   a_eff;
   logic [WORD_W-1:0]   b_eff;
   logic [2*WORD_W-1:0] shifted;
   logic [WORD_W-1:0]   wdata;
   logic                we;
   logic [TW-1:0]       half;
   logic [WORD_W-1:0]   smask;
   logic [WORD_W-1:0]   masked;
   logic [BIT_W-1:0]    enc;
   logic [DW-1:0]       diff;

   assign v_sat = ({7'd0, req_data.value} > 17'(MAX_VALUE)) ? VALUE_W'(MAX_VALUE)
                                                              : req_data.value;
   assign sum_in = SW'(total_ff) + SW'(v_sat);

   assign q        = v_ff[VALUE_W-1:BIT_W];
   assign r        = v_ff[BIT_W-1:0];
   assign src_diff = CW'(k_ff) - CW'(q) - CW'(1);
   assign a_ok     = CW'(k_ff) > CW'(q);
   assign a_addr   = src_diff[AW-1:0];
   assign b_addr   = cmd.sweep ? k_ff[AW-1:0] : sk_ff;

   // words never written read as their cleared value
   assign a_eff = !a_ok_ff ? '0 : (a_vld_ff ? mem_a_ff : WORD_W'(a0_ff));
   assign b_eff = b_vld_ff ? mem_b_ff : WORD_W'(b0_ff);

   assign shifted = {carry_ff, a_eff} << r;
   assign we      = s1_valid_ff && (s1_k_ff < KW'(W));

   always_comb begin
      wdata = shifted[2*WORD_W-1:WORD_W] | b_eff;
      if (s1_k_ff == KW'(W - 1)) begin
         wdata = wdata & TOP_MASK;
      end
   end

   assign half   = total_ff >> 1;
   assign smask  = sfirst_ff ? ({WORD_W{1'b1}} >> (6'd63 - half[BIT_W-1:0]))
                             : {WORD_W{1'b1}};
   assign masked = b_eff & smask;

   always_comb begin
      enc = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (masked[i]) begin
            enc = BIT_W'(i);
         end
      end
   end

   assign diff = DW'(total_ff) - (DW'({sk_ff, enc}) << 1);

   // memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[s1_k_ff[AW-1:0]] <= wdata;
      end
      mem_a_ff <= mem[a_addr];
      mem_b_ff <= mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[s1_k_ff[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_vld_ff <= vld_ff[a_addr];
      b_vld_ff <= vld_ff[b_addr];
      a0_ff    <= (a_addr == '0);
      b0_ff    <= (b_addr == '0);
      a_ok_ff  <= a_ok;
      s1_k_ff  <= k_ff;
      if (s1_valid_ff) begin
         carry_ff <= a_eff;
      end
      if (cmd.load) begin
         v_ff    <= v_sat;
         last_ff <= req_data.last;
      end
      if (cmd.search_init) begin
         sk_ff     <= AW'(half >> BIT_W);
         sfirst_ff <= 1'b1;
      end else if (cmd.search_next) begin
         sk_ff     <= sk_ff - AW'(1);
         sfirst_ff <= 1'b0;
      end
      if (cmd.capture) begin
         if (ovf_ff) begin
            res_ff <= '{min_difference: DIFF_MAX, overflow: 1'b1};
         end else begin
            res_ff.min_difference <= (diff > DW'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(diff);
            res_ff.overflow       <= 1'b0;
         end
      end
      if (cmd.emit) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.sweep;
         if (cmd.emit) begin
            total_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.load) begin
            if (sum_in > SW'(MAX_SUM)) begin
               total_ff <= TW'(MAX_SUM);
               ovf_ff   <= 1'b1;
            end else begin
               total_ff <= sum_in[TW-1:0];
            end
         end
         if (cmd.load) begin
            k_ff <= KW'(W);
         end else if (cmd.sweep) begin
            k_ff <= k_ff - KW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.k_zero   = (k_ff == '0);
   assign status.last     = last_ff;
   assign status.ovf      = ovf_ff;
   assign status.hit      = (masked != '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(MAX_SUM))
      else $error("running total above its limit");

   a_clear_set: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (total_ff == '0 && !ovf_ff && vld_ff == '0))
      else $error("set state not cleared after result");

   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (cmd.search_rd || cmd.search_next) |-> !we)
      else $error("map written during search");
`endif

endmodule

// ===== hw/rtl/min_subset_sum_difference.sv =====
// each element is merged by a shift-or sweep over the W = MAX_SUM/64+1 map words,
//   one word per cycle; the next element is taken only after the sweep
// a last element also scans map words down from half the total (skipped on overflow)
//   then hands off the result; the next element may be taken while a result word waits
// reset: synchronous, clears the map valid bits at once, no clearing pass
// ----------------------------------------------------------------------------
// min_subset_sum_difference
// minimum partition difference over a set of elements via a reachable-sum map
// ----------------------------------------------------------------------------
module min_subset_sum_difference #(
   parameter int MAX_SUM   = 4095,
   parameter int MAX_VALUE = 1023
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mssd_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mssd_pkg::rsp_data_type rsp_data
);
   import mssd_pkg::*;

   cmd_type    cmd;
   status_type status;

   mssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mssd_datapath #(
      .MAX_SUM   (MAX_SUM),
      .MAX_VALUE (MAX_VALUE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
